/* rtl/core/assert_macros.svh */
// Assertion macros used by the checker module of the stack block.
// Depends on nothing; the including module must provide clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/isc_pkg.sv */
// Package of the indexed stack: default sizes, operation and status codes,
// and the control word broadcast to the cell chain. Depends on nothing.
package isc_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int VALUE_BITS_DEF = 32;
  localparam int TAG_BITS_DEF   = 4;

  localparam logic [1:0] MODE_PUSH = 2'd0;
  localparam logic [1:0] MODE_POP  = 2'd1;
  localparam logic [1:0] MODE_PEEK = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic push_en;
    logic pop_en;
  } cell_ctl_t;

endpackage

/* rtl/core/isc_cell.sv */
// One entry of the stack chain, counted from the top. Takes its neighbour's
// entry on an insert above it or a removal at or above it. Depends on isc_pkg.
module isc_cell
  import isc_pkg::*;
#(
  parameter int K          = 0,
  parameter int IDX_W      = 5,
  parameter int TAG_BITS   = TAG_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  cell_ctl_t             ctl,
  input  logic [IDX_W-1:0]      idx,
  input  logic [TAG_BITS-1:0]   new_tag,
  input  logic [VALUE_BITS-1:0] new_value,
  input  logic [TAG_BITS-1:0]   up_tag,
  input  logic [VALUE_BITS-1:0] up_value,
  input  logic [TAG_BITS-1:0]   down_tag,
  input  logic [VALUE_BITS-1:0] down_value,
  output logic [TAG_BITS-1:0]   tag,
  output logic [VALUE_BITS-1:0] value,
  output logic [TAG_BITS-1:0]   hit_tag,
  output logic [VALUE_BITS-1:0] hit_value
);

  localparam logic [IDX_W-1:0] POS = IDX_W'(K);

  logic [TAG_BITS-1:0]   tag_r, tag_nxt;
  logic [VALUE_BITS-1:0] value_r, value_nxt;
  logic                  at_idx, past_idx;

  assign at_idx   = (idx == POS);
  assign past_idx = (POS > idx);

  always_comb begin
    tag_nxt   = tag_r;
    value_nxt = value_r;
    if (ctl.push_en) begin
      if (past_idx) begin
        tag_nxt   = up_tag;
        value_nxt = up_value;
      end else if (at_idx) begin
        tag_nxt   = new_tag;
        value_nxt = new_value;
      end
    end else if (ctl.pop_en) begin
      if (at_idx || past_idx) begin
        tag_nxt   = down_tag;
        value_nxt = down_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    tag_r   <= tag_nxt;
    value_r <= value_nxt;
  end

  assign tag       = tag_r;
  assign value     = value_r;
  assign hit_tag   = at_idx ? tag_r : '0;
  assign hit_value = at_idx ? value_r : '0;

endmodule

/* rtl/core/indexed_stack_insert_remove.sv */
// Top level of the indexed stack: decode, fill count, output register and
// the chain of isc_cell entries. Depends on isc_pkg and isc_cell.
//
// Usage: each input item is a push, pop or peek at a depth counted from the
// top (0 is the top). in_tuser carries the operation, in_tdata the index,
// tag and value. Every item gives exactly one result item on the out_
// channel: the entry read, a status in out_tuser and the depth afterwards.
// A push inserts at the index and moves deeper entries down; a pop removes
// the entry and closes the gap; a peek changes nothing. A bad index, a push
// on a full stack or an unused operation returns an error status with zero
// read fields and leaves the stack untouched.
// out_tvalid rises in the cycle after acceptance. The whole insert or
// removal happens together across the cell chain, so one item is
// taken every cycle while the receiver keeps out_tready high.
// A single output register holds the result; while it is full and the
// receiver stalls, in_tready is low. Reset empties the stack and drops any
// pending result; no clearing pass is needed.
module indexed_stack_insert_remove
  import isc_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int TAG_BITS   = TAG_BITS_DEF,
  localparam int IDX_W      = $clog2(DEPTH + 1),
  localparam int IN_DATA_W  = ((IDX_W + TAG_BITS + VALUE_BITS + 7) / 8) * 8,
  localparam int OUT_DATA_W = ((TAG_BITS + VALUE_BITS + IDX_W + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // depth_index, push_tag, push_value, zero fill
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // mode
  input  logic [1:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // read_tag, read_value, depth_now, zero fill
  output logic [OUT_DATA_W-1:0] out_tdata,
  // status
  output logic [1:0]            out_tuser
);

  localparam logic [IDX_W-1:0] FULL_CNT = IDX_W'(DEPTH);

  logic [IDX_W-1:0]      idx;
  logic [TAG_BITS-1:0]   in_tag;
  logic [VALUE_BITS-1:0] in_value;
  logic [1:0]            mode;
  logic                  accept;
  logic                  push_ok, rd_ok;
  logic [1:0]            status;
  cell_ctl_t             ctl;

  logic [IDX_W-1:0]      fill_r, fill_nxt;
  logic                  out_valid_r;
  logic [TAG_BITS-1:0]   rd_tag_r;
  logic [VALUE_BITS-1:0] rd_value_r;
  logic [IDX_W-1:0]      depth_r;
  logic [1:0]            status_r;

  logic [TAG_BITS-1:0]   cell_tag   [DEPTH];
  logic [VALUE_BITS-1:0] cell_value [DEPTH];
  logic [TAG_BITS-1:0]   hit_tag    [DEPTH];
  logic [VALUE_BITS-1:0] hit_value  [DEPTH];
  logic [TAG_BITS-1:0]   sel_tag;
  logic [VALUE_BITS-1:0] sel_value;

  assign idx      = in_tdata[IDX_W-1:0];
  assign in_tag   = in_tdata[IDX_W +: TAG_BITS];
  assign in_value = in_tdata[IDX_W+TAG_BITS +: VALUE_BITS];
  assign mode     = in_tuser;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    push_ok = 1'b0;
    rd_ok   = 1'b0;
    status  = ST_RANGE;
    unique case (mode)
      MODE_PUSH: begin
        if (idx > fill_r) begin
          status = ST_RANGE;
        end else if (fill_r == FULL_CNT) begin
          status = ST_FULL;
        end else begin
          status  = ST_OK;
          push_ok = 1'b1;
        end
      end
      MODE_POP, MODE_PEEK: begin
        if (idx < fill_r) begin
          status = ST_OK;
          rd_ok  = 1'b1;
        end
      end
      default: status = ST_RANGE;
    endcase
  end

  assign ctl.push_en = accept && push_ok;
  assign ctl.pop_en  = accept && rd_ok && (mode == MODE_POP);

  always_comb begin
    fill_nxt = fill_r;
    if (ctl.push_en) begin
      fill_nxt = fill_r + 1'b1;
    end else if (ctl.pop_en) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [TAG_BITS-1:0]   up_tag, down_tag;
    logic [VALUE_BITS-1:0] up_value, down_value;

    if (k == 0) begin : g_top
      assign up_tag   = in_tag;
      assign up_value = in_value;
    end else begin : g_mid
      assign up_tag   = cell_tag[k-1];
      assign up_value = cell_value[k-1];
    end

    if (k == DEPTH - 1) begin : g_bot
      assign down_tag   = cell_tag[k];
      assign down_value = cell_value[k];
    end else begin : g_low
      assign down_tag   = cell_tag[k+1];
      assign down_value = cell_value[k+1];
    end

    isc_cell #(
      .K          (k),
      .IDX_W      (IDX_W),
      .TAG_BITS   (TAG_BITS),
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .idx        (idx),
      .new_tag    (in_tag),
      .new_value  (in_value),
      .up_tag     (up_tag),
      .up_value   (up_value),
      .down_tag   (down_tag),
      .down_value (down_value),
      .tag        (cell_tag[k]),
      .value      (cell_value[k]),
      .hit_tag    (hit_tag[k]),
      .hit_value  (hit_value[k])
    );
  end

  always_comb begin
    sel_tag   = '0;
    sel_value = '0;
    for (int k = 0; k < DEPTH; k++) begin
      sel_tag   = sel_tag | hit_tag[k];
      sel_value = sel_value | hit_value[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_tag_r   <= rd_ok ? sel_tag : '0;
      rd_value_r <= rd_ok ? sel_value : '0;
      depth_r    <= fill_nxt;
      status_r   <= status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = OUT_DATA_W'({depth_r, rd_value_r, rd_tag_r});

endmodule

/* rtl/core/isc_checker.sv */
// Port-level checker for the indexed stack, bound to the top level.
// Depends on isc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module isc_checker
  import isc_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int TAG_BITS   = TAG_BITS_DEF,
  localparam int IDX_W      = $clog2(DEPTH + 1),
  localparam int OUT_DATA_W = ((TAG_BITS + VALUE_BITS + IDX_W + 7) / 8) * 8
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [1:0]            out_tuser
);

  logic [TAG_BITS-1:0]   rd_tag;
  logic [VALUE_BITS-1:0] rd_value;
  logic [IDX_W-1:0]      depth_now;
  logic                  stalled;
  logic                  is_full;
  logic                  is_err;

  assign rd_tag    = out_tdata[TAG_BITS-1:0];
  assign rd_value  = out_tdata[TAG_BITS +: VALUE_BITS];
  assign depth_now = out_tdata[TAG_BITS+VALUE_BITS +: IDX_W];
  assign stalled   = out_tvalid && !out_tready;
  assign is_full   = out_tvalid && (out_tuser == ST_FULL);
  assign is_err    = out_tvalid && (out_tuser != ST_OK);

  `ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_tvalid, "result pending after reset")
  `ASSERT_CLK(a_hold, stalled |=> out_tvalid && $stable(out_tdata), "stalled item changed")
  `ASSERT_CLK(a_depth, out_tvalid |-> depth_now <= IDX_W'(DEPTH), "depth beyond capacity")
  `ASSERT_CLK(a_full, is_full |-> depth_now == IDX_W'(DEPTH), "full status below capacity")
  `ASSERT_CLK(a_err_zero, is_err |-> rd_tag == '0 && rd_value == '0, "error item carries data")

endmodule

bind indexed_stack_insert_remove isc_checker #(
  .DEPTH      (DEPTH),
  .VALUE_BITS (VALUE_BITS),
  .TAG_BITS   (TAG_BITS)
) u_isc_checker (.*);
